>>> hdl/mclw_pkg.sv
// shared types, constants and helpers for the motor command link watchdog
// no dependencies; used by mclw_core and motor_command_link_watchdog
`default_nettype none

package mclw_pkg;

	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned POS_W   = 2;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// item opcodes
	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_TICK  = 2'd1,
		OP_LEFT  = 2'd2,
		OP_RIGHT = 2'd3
	} op_t;

	// result event codes
	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_APPLIED   = 2'd1,
		EV_REJECTED  = 2'd2,
		EV_WDOG_STOP = 2'd3
	} event_t;

	// drive status codes
	typedef enum logic [1:0] {
		CODE_STOPPED  = 2'd0,
		CODE_FORWARD  = 2'd1,
		CODE_BACKWARD = 2'd2
	} drive_code_t;

	localparam logic [BYTE_W-1:0]  DIR_FORWARD  = 8'h06;
	localparam logic [BYTE_W-1:0]  DIR_BACKWARD = 8'h09;
	localparam logic [BYTE_W-1:0]  DIR_STOP     = 8'h00;
	localparam logic [BYTE_W-1:0]  NIBBLE_MASK  = 8'h0F;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd7200;

	// packet byte slots; the third byte completes a packet
	localparam logic [POS_W-1:0] POS_LAST = 2'd2;

	// register word index (paddr bit 2)
	localparam logic REG_LIMIT = 1'b0;

	typedef struct packed {
		logic [NIB_W-1:0]   drive_nibble;
		logic [BYTE_W-1:0]  left_duty;
		logic [BYTE_W-1:0]  right_duty;
		drive_code_t        drive_code;
		logic [COUNT_W-1:0] left_pulses;
		logic [COUNT_W-1:0] right_pulses;
		event_t             event_res;
	} result_t;

	function automatic drive_code_t code_of(input logic [NIB_W-1:0] nib);
		drive_code_t c;
		if (nib == DIR_FORWARD[NIB_W-1:0]) begin
			c = CODE_FORWARD;
		end else if (nib == DIR_BACKWARD[NIB_W-1:0]) begin
			c = CODE_BACKWARD;
		end else begin
			c = CODE_STOPPED;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hdl/mclw_core.sv
// packet assembly, drive state, watchdog and encoder counters
// depends on mclw_pkg
`default_nettype none

module mclw_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire mclw_pkg::op_t                 opcode,
	input  wire logic [mclw_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic [mclw_pkg::LIMIT_W-1:0]  limit,
	output mclw_pkg::result_t                  res
);

	logic [mclw_pkg::POS_W-1:0]   pos_q, pos_nxt;
	logic [mclw_pkg::BYTE_W-1:0]  held0_q, held1_q;
	logic                         held0_we, held1_we;
	logic [mclw_pkg::LIMIT_W-1:0] wd_q, wd_nxt, wd_inc;
	logic [mclw_pkg::NIB_W-1:0]   drive_q, drive_nxt;
	logic [mclw_pkg::BYTE_W-1:0]  left_q, left_nxt, right_q, right_nxt;
	logic [mclw_pkg::COUNT_W-1:0] lcnt_q, lcnt_nxt, rcnt_q, rcnt_nxt;
	mclw_pkg::event_t             ev;
	logic                         dir_ok;

	assign wd_inc = wd_q + 1'b1;
	assign dir_ok = (held0_q == mclw_pkg::DIR_FORWARD) || (held0_q == mclw_pkg::DIR_BACKWARD)
		|| (held0_q == mclw_pkg::DIR_STOP);

	always_comb begin
		pos_nxt   = pos_q;
		held0_we  = 1'b0;
		held1_we  = 1'b0;
		wd_nxt    = wd_q;
		drive_nxt = drive_q;
		left_nxt  = left_q;
		right_nxt = right_q;
		lcnt_nxt  = lcnt_q;
		rcnt_nxt  = rcnt_q;
		ev        = mclw_pkg::EV_NONE;
		case (opcode)
			mclw_pkg::OP_BYTE: begin
				if (pos_q < mclw_pkg::POS_LAST) begin
					held0_we = ~pos_q[0];
					held1_we = pos_q[0];
					pos_nxt  = pos_q + 1'b1;
				end else begin
					pos_nxt = '0;
					if (dir_ok) begin
						drive_nxt = held0_q[mclw_pkg::NIB_W-1:0];
						left_nxt  = held1_q;
						right_nxt = data_byte;
						wd_nxt    = '0;
						ev        = mclw_pkg::EV_APPLIED;
					end else begin
						ev = mclw_pkg::EV_REJECTED;
					end
				end
			end
			mclw_pkg::OP_TICK: begin
				if (wd_inc >= limit) begin
					wd_nxt    = '0;
					drive_nxt = '0;
					left_nxt  = '0;
					right_nxt = '0;
					lcnt_nxt  = '0;
					rcnt_nxt  = '0;
					ev        = mclw_pkg::EV_WDOG_STOP;
				end else begin
					wd_nxt = wd_inc;
				end
			end
			mclw_pkg::OP_LEFT:  lcnt_nxt = lcnt_q + 1'b1;
			default:            rcnt_nxt = rcnt_q + 1'b1;
		endcase
	end

	// result shows the state after this item
	always_comb begin
		res.drive_nibble = drive_nxt;
		res.left_duty    = left_nxt;
		res.right_duty   = right_nxt;
		res.drive_code   = mclw_pkg::code_of(drive_nxt);
		res.left_pulses  = lcnt_nxt;
		res.right_pulses = rcnt_nxt;
		res.event_res    = ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			wd_q    <= '0;
			drive_q <= '0;
			left_q  <= '0;
			right_q <= '0;
			lcnt_q  <= '0;
			rcnt_q  <= '0;
		end else if (step) begin
			pos_q   <= pos_nxt;
			wd_q    <= wd_nxt;
			drive_q <= drive_nxt;
			left_q  <= left_nxt;
			right_q <= right_nxt;
			lcnt_q  <= lcnt_nxt;
			rcnt_q  <= rcnt_nxt;
		end
	end

	// held packet bytes, no reset
	always_ff @(posedge clk) begin
		if (step && held0_we) begin
			held0_q <= data_byte;
		end
		if (step && held1_we) begin
			held1_q <= data_byte;
		end
	end

endmodule

`default_nettype wire

>>> hdl/motor_command_link_watchdog.sv
// motor command link watchdog: input word register, update core, result register
// an accepted word is registered in stage 1, then its result is registered in the result register (stage 2)
// throughput: one word per cycle while res_stall is low; the core updates all state in a single pass
// the result register frees as it drains, so both stages move together under flow
// reset (arst_n low): motors stopped, counts and packet position zero, limit 7200
// depends on mclw_pkg and mclw_core
`default_nettype none

module motor_command_link_watchdog (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// command words
	input  wire logic                               cmd_valid,
	output logic                                    cmd_stall,
	input  wire logic [1:0]                         opcode,
	input  wire logic [mclw_pkg::BYTE_W-1:0]        data_byte,
	// result words
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output logic [mclw_pkg::NIB_W-1:0]              drive_nibble,
	output logic [mclw_pkg::BYTE_W-1:0]             left_duty,
	output logic [mclw_pkg::BYTE_W-1:0]             right_duty,
	output logic [1:0]                              drive_code,
	output logic [mclw_pkg::COUNT_W-1:0]            left_pulses,
	output logic [mclw_pkg::COUNT_W-1:0]            right_pulses,
	output logic [1:0]                              event_res,
	// register port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [mclw_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [mclw_pkg::PDATA_W-1:0]       pwdata,
	output logic [mclw_pkg::PDATA_W-1:0]            prdata,
	output logic                                    pready
);

	// watchdog limit register
	logic [mclw_pkg::LIMIT_W-1:0] limit_q;
	logic                         reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == mclw_pkg::REG_LIMIT);
	assign prdata  = reg_sel ? {{(mclw_pkg::PDATA_W-mclw_pkg::LIMIT_W){1'b0}}, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= mclw_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			limit_q <= pwdata[mclw_pkg::LIMIT_W-1:0];
		end
	end

	// stage 1: accepted command word
	logic                        valid_s1;
	mclw_pkg::op_t               op_s1;
	logic [mclw_pkg::BYTE_W-1:0] byte_s1;
	logic                        accept;
	logic                        advance;

	// stage 2: result word
	logic                        valid_s2;
	mclw_pkg::result_t           res_s2;
	mclw_pkg::result_t           core_res;

	// stage 1 moves on whenever the result register is empty or draining
	assign advance   = valid_s1 && (!valid_s2 || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= mclw_pkg::op_t'(opcode);
			byte_s1 <= data_byte;
		end
	end

	// state is committed exactly when the word leaves stage 1
	mclw_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.opcode    (op_s1),
		.data_byte (byte_s1),
		.limit     (limit_q),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= core_res;
		end
	end

	assign res_valid    = valid_s2;
	assign drive_nibble = res_s2.drive_nibble;
	assign left_duty    = res_s2.left_duty;
	assign right_duty   = res_s2.right_duty;
	assign drive_code   = res_s2.drive_code;
	assign left_pulses  = res_s2.left_pulses;
	assign right_pulses = res_s2.right_pulses;
	assign event_res    = res_s2.event_res;

`ifndef SYNTHESIS
	// a watchdog stop leaves motors idle and both counts cleared
	a_wdog_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (event_res == mclw_pkg::EV_WDOG_STOP) |->
		(drive_nibble == '0) && (left_duty == '0) && (right_duty == '0)
		&& (left_pulses == '0) && (right_pulses == '0))
		else $error("watchdog stop left drive or counts set");

	// an applied command always drives one of the legal directions
	a_applied_dir: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (event_res == mclw_pkg::EV_APPLIED) |->
		(drive_nibble == mclw_pkg::DIR_FORWARD[mclw_pkg::NIB_W-1:0])
		|| (drive_nibble == mclw_pkg::DIR_BACKWARD[mclw_pkg::NIB_W-1:0])
		|| (drive_nibble == mclw_pkg::DIR_STOP[mclw_pkg::NIB_W-1:0]))
		else $error("applied command with illegal direction");

	// a word that leaves stage 1 under a stalled full result register would be lost
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_stall |-> !advance)
		else $error("result register overwritten while stalled");

	// a stalled input means stage 1 is occupied and the result register is full and stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && valid_s2 && res_stall)
		else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
